/* rtl/core/hkt_pkg.sv */
// Shared types and constants for the held key tracker.
`timescale 1ns / 1ps

package hkt_pkg;

    localparam int HKT_CAPACITY = 16;
    localparam int CODE_W       = 16;
    localparam int KBTYPE_W     = 8;
    localparam int DATA_W       = 24;
    localparam int KIND_W       = 2;
    localparam int ADDR_W       = 2;

    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_NONE_CODE = 2'd0;
    localparam logic [CODE_W-1:0] NONE_CODE_RESET = 16'hFFFF;

    typedef struct packed {
        logic [KBTYPE_W-1:0] kb_type;
        logic [CODE_W-1:0]   code;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } chain_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RELEASE,
        ST_FLUSH
    } state_t;

endpackage

/* rtl/core/hkt_cell.sv */
// One table slot: holds an entry, shifts from its right neighbor or loads the broadcast entry.
`timescale 1ns / 1ps

module hkt_cell (
    input  logic                aclk,
    input  hkt_pkg::chain_ctrl_t ctrl,
    input  hkt_pkg::entry_t      load_data,
    input  hkt_pkg::entry_t      right_data,
    output hkt_pkg::entry_t      data
);
    import hkt_pkg::*;

    entry_t data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            data_reg <= load_data;
        end else if (ctrl.shift) begin
            data_reg <= right_data;
        end
    end

    assign data = data_reg;

endmodule

/* rtl/core/hkt_ctrl.sv */
// Sequencer for the cell chain: append, release compaction and flush walk.
`timescale 1ns / 1ps

module hkt_ctrl #(
    parameter int CAPACITY = hkt_pkg::HKT_CAPACITY
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hkt_pkg::KIND_W-1:0]  in_kind,
    input  hkt_pkg::entry_t             in_entry,
    input  logic [hkt_pkg::CODE_W-1:0]  none_code,
    input  hkt_pkg::entry_t             head,
    input  logic                        out_free,
    output hkt_pkg::chain_ctrl_t        ctrl,
    output logic [$clog2(CAPACITY)-1:0] load_idx,
    output hkt_pkg::entry_t             bcast,
    output logic                        emit,
    output logic                        emit_last
);
    import hkt_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   kept_reg, kept_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]   ins_reg, ins_next;
    entry_t             key_reg, key_next;

    logic               accept;
    logic               match;
    logic               last_step;
    logic               press_ok;
    logic [CNT_W-1:0]   count_m1;

    assign accept    = in_valid && in_ready;
    assign match     = (head == key_reg);
    assign last_step = ((CNT_W'(step_reg) + CNT_W'(1)) == count_reg);
    assign count_m1  = count_reg - CNT_W'(1);
    assign press_ok  = (in_entry.code != none_code) && (count_reg < CNT_W'(CAPACITY));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (count_reg != '0)) begin
                    if (in_kind == KIND_RELEASE) begin
                        state_next = ST_RELEASE;
                    end else if (in_kind == KIND_FLUSH) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_RELEASE: begin
                if (last_step) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (out_free && last_step) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = (state_reg == ST_IDLE);
        ctrl       = '0;
        load_idx   = ins_reg;
        bcast      = head;
        emit       = 1'b0;
        emit_last  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                bcast    = in_entry;
                load_idx = count_reg[IDX_W-1:0];
                if (accept && (in_kind == KIND_PRESS) && press_ok) begin
                    ctrl.load = 1'b1;
                end
            end
            ST_RELEASE: begin
                // head leaves the chain; survivors re-enter behind the unvisited entries
                ctrl.shift = 1'b1;
                ctrl.load  = !match;
            end
            ST_FLUSH: begin
                if (out_free) begin
                    ctrl.shift = 1'b1;
                    emit       = 1'b1;
                    emit_last  = last_step;
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        kept_next  = kept_reg;
        step_next  = step_reg;
        ins_next   = ins_reg;
        key_next   = key_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    key_next  = in_entry;
                    step_next = '0;
                    kept_next = '0;
                    ins_next  = count_m1[IDX_W-1:0];
                    if ((in_kind == KIND_PRESS) && press_ok) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_RELEASE: begin
                step_next = step_reg + IDX_W'(1);
                kept_next = kept_reg + CNT_W'(!match);
                if (match) begin
                    ins_next = ins_reg - IDX_W'(1);
                end
                if (last_step) begin
                    count_next = kept_reg + CNT_W'(!match);
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    step_next = step_reg + IDX_W'(1);
                    if (last_step) begin
                        count_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            kept_reg  <= '0;
            step_reg  <= '0;
            ins_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            kept_reg  <= kept_next;
            step_reg  <= step_next;
            ins_reg   <= ins_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

/* rtl/core/held_key_tracker.sv */
// Top level of the held key tracker: config register, cell chain, sequencer, output register.
// Press and ignored items do not hold the input; a release walks the held entries, one per cycle,
// and no further item is taken until the walk is done.
// A flush emits one result per cycle from the head cell while the output side keeps up,
// the first result loaded into the output register once the flush state is entered; output stalls hold the walk.
// Synchronous active-low reset empties the table, clears the output and sets none_code to FFFF.
`timescale 1ns / 1ps

module held_key_tracker #(
    parameter int CAPACITY = hkt_pkg::HKT_CAPACITY
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [hkt_pkg::DATA_W-1:0]  s_tdata,  // [15:0] key_code, [23:16] keyboard_type
    input  logic [hkt_pkg::KIND_W-1:0]  s_tuser,  // [1:0] kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [hkt_pkg::DATA_W-1:0]  m_tdata,  // [15:0] release_key_code, [23:16] release_keyboard_type
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hkt_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import hkt_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    logic [CODE_W-1:0]  none_code_reg;
    entry_t             cells [CAPACITY];
    entry_t             in_entry;
    entry_t             bcast;
    chain_ctrl_t        ctrl;
    logic [IDX_W-1:0]   load_idx;
    logic               emit;
    logic               emit_last;
    logic               out_free;
    logic               out_valid_reg;
    entry_t             out_data_reg;
    logic               out_last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_NONE_CODE) ? {16'd0, none_code_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            none_code_reg <= NONE_CODE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_NONE_CODE)) begin
            none_code_reg <= pwdata[CODE_W-1:0];
        end
    end

    assign in_entry = entry_t'(s_tdata);
    assign out_free = !out_valid_reg || m_tready;

    hkt_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_entry  (in_entry),
        .none_code (none_code_reg),
        .head      (cells[0]),
        .out_free  (out_free),
        .ctrl      (ctrl),
        .load_idx  (load_idx),
        .bcast     (bcast),
        .emit      (emit),
        .emit_last (emit_last)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        chain_ctrl_t cell_ctrl;
        entry_t      right;

        assign cell_ctrl = '{shift: ctrl.shift, load: ctrl.load && (load_idx == IDX_W'(i))};
        if (i == CAPACITY - 1) begin : g_tail
            assign right = cells[i];
        end else begin : g_mid
            assign right = cells[i+1];
        end

        hkt_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .load_data  (bcast),
            .right_data (right),
            .data       (cells[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= cells[0];
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/core/hkt_checker.sv */
// Port-level assertions for the held key tracker, bound to the top level.
`timescale 1ns / 1ps

module hkt_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [hkt_pkg::KIND_W-1:0]  s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [hkt_pkg::DATA_W-1:0]  m_tdata,
    input logic                        m_tlast
);
    import hkt_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // no input is taken while a flush run is still in flight
    a_flush_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a flush");

    // a flush run streams without gaps while the output side keeps up
    a_flush_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a flush run");

    // press and release never make a result
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != KIND_FLUSH) && !m_tvalid |=> !m_tvalid)
        else $error("result after a press or release");

endmodule

bind held_key_tracker hkt_checker u_hkt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* verif/tb_held_key_tracker.sv */
// Self-checking testbench for held_key_tracker: directed and random key events with stalls.
`timescale 1ns / 1ps

module tb_held_key_tracker;
    import hkt_pkg::*;

    localparam int CAPACITY    = HKT_CAPACITY;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 500000;
    localparam int MAX_REPORTS = 20;
    // kind value with no meaning; the block must ignore it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        entry_t ent;
        logic   last;
    } release_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;   // [15:0] key_code, [23:16] keyboard_type
    logic [KIND_W-1:0]   s_tuser;   // [1:0] kind
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;   // [15:0] release_key_code, [23:16] release_keyboard_type
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state
    entry_t      held_table[$];
    logic [15:0] none_code_model;
    release_t    expected_releases[$];

    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_count = 0;
    int rx_hold_taken = 0;
    int rx_hold_left = 0;
    int cycle_count = 0;
    int error_count;
    int items_sent;
    int flushes_sent;
    int results_checked;
    int dropped_full;
    int dropped_none;

    held_key_tracker #(.CAPACITY(CAPACITY)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_releases.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH %s: got %h, expected %h (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    // receiver: random stalls, plus a long hold-off counted down here
    always @(posedge aclk) begin
        if (rx_hold_taken != rx_hold_count) begin
            rx_hold_taken <= rx_hold_count;
            rx_hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        release_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_releases.size() == 0) begin
                report_mismatch("result with nothing expected", 32'({m_tlast, m_tdata}),
                                32'h0);
            end else begin
                want = expected_releases.pop_front();
                results_checked++;
                if (m_tdata[CODE_W-1:0] !== want.ent.code)
                    report_mismatch("release_key_code", 32'(m_tdata[CODE_W-1:0]),
                                    32'(want.ent.code));
                if (m_tdata[CODE_W+KBTYPE_W-1:CODE_W] !== want.ent.kb_type)
                    report_mismatch("release_keyboard_type",
                                    32'(m_tdata[CODE_W+KBTYPE_W-1:CODE_W]),
                                    32'(want.ent.kb_type));
                if (m_tlast !== want.last)
                    report_mismatch("last_release", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // table update for one accepted key event; flush queues its releases
    function automatic void predict_key_event(input logic [KIND_W-1:0] kind, input entry_t ev);
        entry_t   kept[$];
        release_t rel;
        case (kind)
            KIND_PRESS: begin
                if (ev.code == none_code_model)
                    dropped_none++;
                else if (held_table.size() >= CAPACITY)
                    dropped_full++;
                else
                    held_table = {held_table, ev};
            end
            KIND_RELEASE: begin
                foreach (held_table[i])
                    if (held_table[i] != ev)
                        kept = {kept, held_table[i]};
                held_table = kept;
            end
            KIND_FLUSH: begin
                flushes_sent++;
                foreach (held_table[i]) begin
                    rel.ent = held_table[i];
                    rel.last = (i == held_table.size() - 1);
                    expected_releases = {expected_releases, rel};
                end
                held_table.delete();
            end
            default: ;
        endcase
    endfunction

    // valid stays high after a transfer until the next call or stop_sending
    task automatic send_item(input logic [KIND_W-1:0] kind, input entry_t ev);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= ev;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        predict_key_event(kind, ev);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic pause_until_drained();
        stop_sending();
        while (expected_releases.size() != 0)
            @(posedge aclk);
    endtask

    // a release with no result may still be walking the table
    task automatic drain_results();
        pause_until_drained();
        repeat (CAPACITY + 8) @(posedge aclk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    // write none_code, then read it back in a back-to-back transfer
    task automatic write_none_code(input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_NONE_CODE;
        pwdata <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        none_code_model = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[CODE_W-1:0] !== value)
            report_mismatch("none_code readback", prdata, {16'h0, value});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_basic_ops();
        set_idling(0, 0);
        send_item(KIND_FLUSH, '{kb_type: 8'h00, code: 16'h0000});   // empty table
        send_item(KIND_PRESS, '{kb_type: 8'h00, code: 16'h0000});
        send_item(KIND_PRESS, '{kb_type: 8'h3C, code: 16'hFFFF});   // no-key code at reset
        send_item(KIND_PRESS, '{kb_type: 8'hFF, code: 16'hFFFE});
        send_item(KIND_PRESS, '{kb_type: 8'h56, code: 16'h1234});
        send_item(KIND_PRESS, '{kb_type: 8'h56, code: 16'h1234});
        send_item(KIND_PRESS, '{kb_type: 8'h57, code: 16'h1234});
        send_item(KIND_UNUSED, '{kb_type: 8'hA5, code: 16'h5A5A});
        send_item(KIND_RELEASE, '{kb_type: 8'h56, code: 16'h1234}); // both duplicates go
        send_item(KIND_RELEASE, '{kb_type: 8'h56, code: 16'h4321}); // no match
        send_item(KIND_FLUSH, '{kb_type: 8'hFF, code: 16'hFFFF});
        drain_results();
    endtask

    task automatic test_full_table();
        set_idling(0, 0);
        for (int i = 0; i <= CAPACITY; i++)
            send_item(KIND_PRESS, '{kb_type: 8'(i * 17), code: 16'(i * 16'h0F0F + 1)});
        send_item(KIND_RELEASE, '{kb_type: 8'(5 * 17), code: 16'(5 * 16'h0F0F + 1)});
        send_item(KIND_FLUSH, '{kb_type: 8'h00, code: 16'h0000});
        drain_results();
    endtask

    task automatic test_none_code_register();
        write_none_code(16'h0000);
        send_item(KIND_PRESS, '{kb_type: 8'h01, code: 16'h0000});
        send_item(KIND_PRESS, '{kb_type: 8'h80, code: 16'hFFFF});
        send_item(KIND_FLUSH, '{kb_type: 8'h00, code: 16'h0000});
        drain_results();
    endtask

    // mostly presses and releases of a small key set, so releases hit real entries
    task automatic run_random_phase(input int n_items, input int tx_pct, input int rx_pct,
                                    input logic [15:0] nc, input int press_pct);
        entry_t pool[8];
        entry_t ev;
        int     roll;
        write_none_code(nc);
        set_idling(tx_pct, rx_pct);
        for (int i = 0; i < 8; i++) begin
            pool[i].code = (i > 0 && $urandom_range(3) == 0) ? pool[i-1].code : 16'($urandom);
            pool[i].kb_type = 8'($urandom);
        end
        pool[7].code = nc;
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            ev = pool[$urandom_range(7)];
            if (roll < press_pct)
                send_item(KIND_PRESS, ev);
            else if (roll < press_pct + 25)
                send_item(KIND_RELEASE, ev);
            else if (roll < press_pct + 37)
                send_item(KIND_FLUSH, 24'($urandom));
            else if (roll < press_pct + 40)
                send_item(KIND_UNUSED, 24'($urandom));
            else
                send_item($urandom_range(1) ? KIND_PRESS : KIND_RELEASE, 24'($urandom));
        end
        drain_results();
    endtask

    // output held off while the table fills and flushes; input must stall
    task automatic test_output_hold();
        set_idling(0, 0);
        rx_hold_count++;
        for (int i = 0; i < CAPACITY; i++)
            send_item(KIND_PRESS, '{kb_type: 8'($urandom), code: 16'($urandom_range(16'hFFFE))});
        send_item(KIND_FLUSH, 24'($urandom));
        for (int i = 0; i < 6; i++) begin
            send_item(KIND_PRESS, '{kb_type: 8'($urandom), code: 16'($urandom_range(16'hFFFE))});
            send_item(KIND_FLUSH, 24'($urandom));
        end
        pause_until_drained();
        for (int i = 0; i < 4; i++)
            send_item(KIND_PRESS, '{kb_type: 8'($urandom), code: 16'($urandom_range(16'hFFFE))});
        send_item(KIND_FLUSH, 24'($urandom));
        drain_results();
    endtask

    initial begin
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= KIND_PRESS;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_NONE_CODE;
        pwdata <= '0;
        aresetn <= 1'b0;
        error_count = 0;
        items_sent = 0;
        flushes_sent = 0;
        results_checked = 0;
        dropped_full = 0;
        dropped_none = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        none_code_model = NONE_CODE_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_ops();
        test_full_table();
        test_none_code_register();
        run_random_phase(65, 0, 0, 16'($urandom), 50);
        run_random_phase(65, 81, 0, 16'($urandom), 58);
        run_random_phase(65, 0, 81, 16'($urandom), 45);
        run_random_phase(65, 9, 9, 16'hFFFF, 50);
        test_output_hold();
        drain_results();

        if (expected_releases.size() != 0)
            report_mismatch("releases never seen", 32'(expected_releases.size()), 32'h0);
        $display("Covered %0d key events (%0d flushes), %0d releases checked",
                 items_sent, flushes_sent, results_checked);
        $display("Presses dropped: %0d on full table, %0d on no-key code; %0d mismatches",
                 dropped_full, dropped_none, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
